@@ rtl/core/hsv_pkg.sv @@
// shared types for the hsv to rgb565 pipeline
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

   typedef struct packed {
      logic [2:0]  sector;
      logic        s_zero;
      logic [7:0]  v;
      logic [15:0] sf;
      logic [16:0] sfc;
      logic [8:0]  sc;
   } s1_type;

   typedef struct packed {
      logic [2:0]  sector;
      logic        s_zero;
      logic [23:0] vv;
      logic [23:0] pp;
      logic [23:0] qq;
      logic [23:0] tt;
   } s2_type;

endpackage

`default_nettype wire

@@ rtl/core/hsv_s1.sv @@
// stage 1: hue sector, fraction and saturation products
`timescale 1ns / 1ps
`default_nettype none

module hsv_s1 (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [7:0]     hue,
   input  wire logic [7:0]     saturation,
   input  wire logic [7:0]     brightness,
   output hsv_pkg::s1_type     s1_ff
);
   import hsv_pkg::*;

   logic [10:0] h6;
   logic [7:0]  f;
   logic [8:0]  fc;
   s1_type      s1_in;

   always_comb begin
      h6            = {hue, 3'b0} - {2'b0, hue, 1'b0};
      f             = h6[7:0];
      fc            = 9'd256 - {1'b0, f};
      s1_in.sector  = h6[10:8];
      s1_in.s_zero  = (saturation == 8'd0);
      s1_in.v       = brightness;
      s1_in.sf      = {8'b0, saturation} * {8'b0, f};
      s1_in.sfc     = {9'b0, saturation} * {8'b0, fc};
      s1_in.sc      = 9'd256 - {1'b0, saturation};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hsv_s2.sv @@
// stage 2: v, p, q and t on the 2^24 scale
`timescale 1ns / 1ps
`default_nettype none

module hsv_s2 (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire hsv_pkg::s1_type s1,
   output hsv_pkg::s2_type     s2_ff
);
   import hsv_pkg::*;

   logic [16:0] q_k;
   logic [16:0] t_k;
   logic [24:0] q_m;
   logic [24:0] t_m;
   logic [16:0] p_m;
   s2_type      s2_in;

   always_comb begin
      q_k          = 17'h10000 - {1'b0, s1.sf};
      t_k          = 17'h10000 - s1.sfc;
      q_m          = {17'b0, s1.v} * {8'b0, q_k};
      t_m          = {17'b0, s1.v} * {8'b0, t_k};
      p_m          = {9'b0, s1.v} * {8'b0, s1.sc};
      s2_in.sector = s1.sector;
      s2_in.s_zero = s1.s_zero;
      s2_in.vv     = {s1.v, 16'b0};
      s2_in.pp     = {p_m[15:0], 8'b0};
      s2_in.qq     = q_m[23:0];
      s2_in.tt     = t_m[23:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff <= s2_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hsv_s3.sv @@
// stage 3: channel select, scale to 8 bits and rgb565 pack
`timescale 1ns / 1ps
`default_nettype none

module hsv_s3 (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire hsv_pkg::s2_type s2,
   output logic [15:0]         color_ff
);
   import hsv_pkg::*;

   localparam logic [2:0] SEC_RY = 3'd0;
   localparam logic [2:0] SEC_YG = 3'd1;
   localparam logic [2:0] SEC_GC = 3'd2;
   localparam logic [2:0] SEC_CB = 3'd3;
   localparam logic [2:0] SEC_BM = 3'd4;

   function automatic logic [7:0] chan8(input logic [23:0] x);
      logic [31:0] m;
      m = {x, 8'b0} - {8'b0, x};
      return m[31:24];
   endfunction

   logic [23:0] r;
   logic [23:0] g;
   logic [23:0] b;
   logic [7:0]  r8;
   logic [7:0]  g8;
   logic [7:0]  b8;
   logic [15:0] color_in;

   always_comb begin
      if (s2.s_zero) begin
         r = s2.vv; g = s2.vv; b = s2.vv;
      end else begin
         case (s2.sector)
            SEC_RY: begin r = s2.vv; g = s2.tt; b = s2.pp; end
            SEC_YG: begin r = s2.qq; g = s2.vv; b = s2.pp; end
            SEC_GC: begin r = s2.pp; g = s2.vv; b = s2.tt; end
            SEC_CB: begin r = s2.pp; g = s2.qq; b = s2.vv; end
            SEC_BM: begin r = s2.tt; g = s2.pp; b = s2.vv; end
            default: begin r = s2.vv; g = s2.pp; b = s2.qq; end
         endcase
      end
      r8       = chan8(r);
      g8       = chan8(g);
      b8       = chan8(b);
      color_in = {r8[7:3], g8[7:2], b8[7:3]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         color_ff <= color_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb565.sv @@
// hsv to rgb565 converter, three register stages
// a req beat passes the s1, s2 and s3 registers before rsp_valid rises, later under rsp stall
// throughput: one beat per cycle while rsp_stall is low; a stage loads when it is empty or
// the stage after it loads, so bubbles close up under a rsp stall
// reset: synchronous, clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb565 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_hue,
   input  wire logic [7:0]  req_saturation,
   input  wire logic [7:0]  req_brightness,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_color565
);
   import hsv_pkg::*;

   logic    v1_ff, v2_ff, v3_ff;
   logic    v1_in, v2_in, v3_in;
   logic    en1, en2, en3;
   s1_type  s1;
   s2_type  s2;

   always_comb begin
      en3       = !v3_ff || !rsp_stall;
      en2       = en3 || !v2_ff;
      en1       = en2 || !v1_ff;
      req_stall = !en1;
      v1_in     = en1 ? req_valid : v1_ff;
      v2_in     = en2 ? v1_ff : v2_ff;
      v3_in     = en3 ? v2_ff : v3_ff;
      rsp_valid = v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   hsv_s1 u_s1 (
      .clock      (clock),
      .en         (en1),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .s1_ff      (s1)
   );

   hsv_s2 u_s2 (
      .clock (clock),
      .en    (en2),
      .s1    (s1),
      .s2_ff (s2)
   );

   hsv_s3 u_s3 (
      .clock    (clock),
      .en       (en3),
      .s2       (s2),
      .color_ff (rsp_color565)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("req stalled with room in the pipeline");

   a_grey_terms: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && s2.s_zero) |-> (s2.pp == s2.vv && s2.qq == s2.vv && s2.tt == s2.vv))
      else $error("zero saturation terms differ from v");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!v1_ff && !v2_ff && !rsp_valid))
      else $error("pipeline not empty after reset");

   a_bubble_fill: assert property (@(posedge clock) disable iff (reset)
      (!v3_ff && v2_ff) |=> v3_ff)
      else $error("stage 3 did not take a waiting beat");

endmodule

`default_nettype wire
